FILE: rtl/core/assert_macros.svh
// Assertion macros for the port checker module of the top-k selector.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define WSTK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// The condition must never be seen at a rising edge outside reset.
`define WSTK_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: rtl/core/wstk_pkg.sv
// Shared types and constants of the weighted similarity top-k selector.
// Used by the insertion cell, the top level and the port checker.
package wstk_pkg;

    // Default sizes, handed to the top level's parameters.
    localparam int K_DEF           = 8;
    localparam int MAX_ENTRIES_DEF = 1024;

    // Fixed field widths.
    localparam int SCORE_W    = 16;
    localparam int IMP_W      = 17;
    localparam int INDEX_W    = 10;
    localparam int TOPK_W     = 4;
    localparam int RANK_W     = 3;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 17;
    localparam int PROD_W     = SCORE_W + IMP_W + 1;

    // Command codes of the candidate channel.
    localparam logic CMD_CANDIDATE = 1'b0;
    localparam logic CMD_FINISH    = 1'b1;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_TOP_K    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMP_GATE = 1'b1;

    // Reset values and fixed-point constants.
    localparam logic [TOPK_W-1:0] TOP_K_RESET    = 4'd8;
    localparam logic [IMP_W-1:0]  IMP_GATE_RESET = 17'd3277;
    localparam logic [IMP_W-1:0]  IMP_ONE        = 17'd65536;

    // One candidate or finish command.
    typedef struct packed {
        logic                      command;
        logic signed [SCORE_W-1:0] similarity;
        logic [IMP_W-1:0]          importance;
        logic [INDEX_W-1:0]        entry_index;
        logic                      entry_active;
        logic                      user_match;
    } cand_t;

    // One ranked result.
    typedef struct packed {
        logic [RANK_W-1:0]         rank;
        logic signed [SCORE_W-1:0] best_score;
        logic [INDEX_W-1:0]        best_index;
        logic                      none_found;
        logic                      last;
    } res_t;

    // Broadcast control from the top level to every cell of the chain.
    typedef struct packed {
        logic                      insert;
        logic                      shift;
        logic                      full;
        logic signed [SCORE_W-1:0] score;
        logic [INDEX_W-1:0]        index;
    } cell_ctrl_t;

endpackage

FILE: rtl/core/wstk_cell.sv
// One position of the sorted insertion chain: holds a kept score and slot.
// Depends on wstk_pkg for the broadcast control struct and field widths.
module wstk_cell import wstk_pkg::*;
(
    input  logic                      clk,
    input  cell_ctrl_t                ctrl,
    input  logic                      at_pos,
    input  logic                      below_pos,
    input  logic                      prev_lt,
    input  logic signed [SCORE_W-1:0] prev_score,
    input  logic [INDEX_W-1:0]        prev_index,
    input  logic signed [SCORE_W-1:0] next_score,
    input  logic [INDEX_W-1:0]        next_index,
    output logic                      lt,
    output logic signed [SCORE_W-1:0] score,
    output logic [INDEX_W-1:0]        index
);

    logic signed [SCORE_W-1:0] score_reg;
    logic signed [SCORE_W-1:0] score_next;
    logic [INDEX_W-1:0]        index_reg;
    logic [INDEX_W-1:0]        index_next;

    // The new score goes at or above this position. At the insertion limit an
    // open slot always takes it; a full list only on a strictly greater score.
    assign lt = (below_pos && (score_reg < ctrl.score)) ||
                (at_pos && (!ctrl.full || (score_reg < ctrl.score)));

    // Take the new entry at the first losing position, the upper neighbour's
    // entry below it, or the lower neighbour's entry while the list drains.
    always_comb
    begin
        score_next = score_reg;
        index_next = index_reg;
        if (ctrl.insert && lt)
        begin
            if (prev_lt)
            begin
                score_next = prev_score;
                index_next = prev_index;
            end
            else
            begin
                score_next = ctrl.score;
                index_next = ctrl.index;
            end
        end
        else if (ctrl.shift)
        begin
            score_next = next_score;
            index_next = next_index;
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        index_reg <= index_next;
    end

    assign score = score_reg;
    assign index = index_reg;

endmodule

FILE: rtl/core/weighted_similarity_top_k_unit.sv
// Top level of the weighted similarity top-k selector: filter, score, chain.
// Depends on wstk_pkg and instantiates one wstk_cell per kept position.

// Candidates are taken one per cycle: the weighted score is formed by one
// 16 by 17 bit multiplier into a register, and in the following cycle every
// cell of the chain compares it with its own kept score and takes the new
// entry, its neighbour's entry or keeps its own, so a stream of candidates
// flows without pause. A finish command holds the candidate channel off from
// the cycle after its transfer until the last result has left the emission
// logic: the list drains from the head of the chain one result per cycle of
// free output register, giving min(count, top_k) results, or one result when
// nothing was kept, and the block is then ready for the next scan.
module weighted_similarity_top_k_unit import wstk_pkg::*;
#(
    parameter int K           = K_DEF,
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cand_valid,
    output logic                  cand_stall,
    input  cand_t                 cand,
    output logic                  res_valid,
    input  logic                  res_stall,
    output res_t                  res,
    input  logic                  cfg_wr,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int KB = (K < MAX_ENTRIES) ? K : MAX_ENTRIES;
    localparam int CW = $clog2(KB + 1);
    localparam int MW = (CW > TOPK_W) ? CW : TOPK_W;
    localparam int EW = $clog2(MAX_ENTRIES + 1);
    localparam int XW = (EW > INDEX_W) ? EW : INDEX_W;
    localparam logic [MW-1:0] KB_M   = MW'(KB);
    localparam logic [XW-1:0] MAX_EX = XW'(MAX_ENTRIES);

    // Configuration registers.
    logic [TOPK_W-1:0] top_k_reg;
    logic [IMP_W-1:0]  imp_gate_reg;

    // Score stage.
    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    logic                      s1_finish_reg;
    logic signed [SCORE_W-1:0] s1_score_reg;
    logic [INDEX_W-1:0]        s1_index_reg;

    // Chain and emission control.
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              emit_active_reg;
    logic              emit_active_next;
    logic              emit_none_reg;
    logic              emit_none_next;
    logic [CW-1:0]     remain_reg;
    logic [CW-1:0]     remain_next;
    logic [RANK_W-1:0] rank_reg;
    logic [RANK_W-1:0] rank_next;

    // Output register.
    logic res_valid_reg;
    logic res_valid_next;
    res_t res_reg;
    res_t res_next;

    logic                      cand_take;
    logic [IMP_W-1:0]          imp_sat;
    logic                      qualify;
    logic signed [PROD_W-1:0]  prod;
    logic [CW-1:0]             k_eff;
    logic                      full;
    logic [CW-1:0]             ins_pos;
    logic [CW-1:0]             keep_n;
    logic                      emit_fire;
    cell_ctrl_t                ctrl;

    logic                      lt_vec    [KB];
    logic signed [SCORE_W-1:0] score_vec [KB];
    logic [INDEX_W-1:0]        index_vec [KB];

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_k_reg    <= TOP_K_RESET;
            imp_gate_reg <= IMP_GATE_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_addr)
                REG_TOP_K:    top_k_reg    <= cfg_wdata[TOPK_W-1:0];
                REG_IMP_GATE: imp_gate_reg <= cfg_wdata[IMP_W-1:0];
                default:      top_k_reg    <= top_k_reg;
            endcase
        end
    end

    // Keep count bounded by the chain length.
    assign k_eff = (MW'(top_k_reg) > KB_M) ? CW'(KB) : CW'(top_k_reg);

    // Input transfer and candidate filtering.
    assign cand_stall = emit_active_reg || (s1_valid_reg && s1_finish_reg);
    assign cand_take  = cand_valid && !cand_stall;
    assign imp_sat    = (cand.importance > IMP_ONE) ? IMP_ONE : cand.importance;
    assign qualify    = cand.entry_active && cand.user_match &&
                        (XW'(cand.entry_index) < MAX_EX) && (imp_sat >= imp_gate_reg);

    // Weighted score: the product lies in 32 signed bits, bits 31..16 are the floor.
    assign prod = $signed(cand.similarity) * $signed({1'b0, imp_sat});

    assign s1_valid_next = cand_take && ((cand.command == CMD_FINISH) || qualify);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cand_take)
        begin
            s1_finish_reg <= (cand.command == CMD_FINISH);
            s1_score_reg  <= prod[31:16];
            s1_index_reg  <= cand.entry_index;
        end
    end

    // Insertion limit: the next open slot, or the last kept place when full.
    assign full    = (count_reg >= k_eff);
    assign ins_pos = full ? (k_eff - CW'(1)) : count_reg;
    assign keep_n  = (count_reg > k_eff) ? k_eff : count_reg;

    assign emit_fire = emit_active_reg && (!res_valid_reg || !res_stall);

    // Control broadcast to the chain.
    always_comb
    begin
        ctrl.insert = s1_valid_reg && !s1_finish_reg && (k_eff != '0);
        ctrl.shift  = emit_fire && !emit_none_reg;
        ctrl.full   = full;
        ctrl.score  = s1_score_reg;
        ctrl.index  = s1_index_reg;
    end

    // Fill count, emission sequencing and the output register.
    always_comb
    begin
        count_next       = count_reg;
        emit_active_next = emit_active_reg;
        emit_none_next   = emit_none_reg;
        remain_next      = remain_reg;
        rank_next        = rank_reg;
        res_next         = res_reg;
        res_valid_next   = res_valid_reg && res_stall;

        if (ctrl.insert && !full)
        begin
            count_next = count_reg + CW'(1);
        end

        if (s1_valid_reg && s1_finish_reg)
        begin
            count_next       = '0;
            emit_active_next = 1'b1;
            emit_none_next   = (keep_n == '0);
            remain_next      = keep_n;
            rank_next        = '0;
        end

        if (emit_fire)
        begin
            res_valid_next = 1'b1;
            if (emit_none_reg)
            begin
                res_next.rank       = '0;
                res_next.best_score = '0;
                res_next.best_index = '0;
                res_next.none_found = 1'b1;
                res_next.last       = 1'b1;
                emit_active_next    = 1'b0;
            end
            else
            begin
                res_next.rank       = rank_reg;
                res_next.best_score = score_vec[0];
                res_next.best_index = index_vec[0];
                res_next.none_found = 1'b0;
                res_next.last       = (remain_reg == CW'(1));
                remain_next         = remain_reg - CW'(1);
                rank_next           = rank_reg + RANK_W'(1);
                if (remain_reg == CW'(1))
                begin
                    emit_active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            emit_active_reg <= 1'b0;
            emit_none_reg   <= 1'b0;
            remain_reg      <= '0;
            rank_reg        <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            emit_active_reg <= emit_active_next;
            emit_none_reg   <= emit_none_next;
            remain_reg      <= remain_next;
            rank_reg        <= rank_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // The insertion chain, head at position zero.
    for (genvar i = 0; i < KB; i++)
    begin : g_cell
        logic                      prev_lt;
        logic signed [SCORE_W-1:0] prev_score;
        logic [INDEX_W-1:0]        prev_index;
        logic signed [SCORE_W-1:0] next_score;
        logic [INDEX_W-1:0]        next_index;

        if (i == 0)
        begin : g_head
            assign prev_lt    = 1'b0;
            assign prev_score = '0;
            assign prev_index = '0;
        end
        else
        begin : g_body
            assign prev_lt    = lt_vec[i-1];
            assign prev_score = score_vec[i-1];
            assign prev_index = index_vec[i-1];
        end

        if (i == KB - 1)
        begin : g_tail
            assign next_score = '0;
            assign next_index = '0;
        end
        else
        begin : g_link
            assign next_score = score_vec[i+1];
            assign next_index = index_vec[i+1];
        end

        wstk_cell u_cell
        (
            .clk        (clk),
            .ctrl       (ctrl),
            .at_pos     (ins_pos == CW'(i)),
            .below_pos  (CW'(i) < ins_pos),
            .prev_lt    (prev_lt),
            .prev_score (prev_score),
            .prev_index (prev_index),
            .next_score (next_score),
            .next_index (next_index),
            .lt         (lt_vec[i]),
            .score      (score_vec[i]),
            .index      (index_vec[i])
        );
    end

endmodule

FILE: rtl/core/wstk_checker.sv
// Port-level checker of the top-k selector, bound to the top level.
// Depends on wstk_pkg and the macros of assert_macros.svh.
`include "assert_macros.svh"

module wstk_checker import wstk_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  cand_valid,
    input logic  cand_stall,
    input cand_t cand,
    input logic  res_valid,
    input logic  res_stall,
    input res_t  res
);

    // A stalled result stays on the port unchanged.
    `WSTK_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res), "result changed while stalled")

    // An empty scan answers with a single zeroed final result.
    `WSTK_ASSERT_NEVER(a_none_shape, res_valid && res.none_found && (!res.last || res.rank != '0 || res.best_score != '0 || res.best_index != '0), "malformed none result")

    // The transfer of a finish command closes the candidate channel.
    `WSTK_ASSERT(a_finish_stall, cand_valid && !cand_stall && cand.command == CMD_FINISH |=> cand_stall, "candidate channel open after finish")

    // No candidate is taken while a result run is still being emitted.
    `WSTK_ASSERT(a_run_stall, res_valid && !res.last |-> cand_stall, "candidate channel open during emission")

endmodule

bind weighted_similarity_top_k_unit wstk_checker u_wstk_checker (.*);

FILE: bench/topk_checker.sv
// Transfer monitor and result predictor for the weighted similarity top-k selector.
// Depends on wstk_pkg; it mirrors the configuration writes and the kept list.
module topk_checker import wstk_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cand_valid,
    input  logic                  cand_stall,
    input  cand_t                 cand,
    input  logic                  res_valid,
    input  logic                  res_stall,
    input  res_t                  res,
    input  logic                  cfg_wr,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatch_count,
    output int                    results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    // Mirrored registers and the predicted ranking.
    logic [TOPK_W-1:0]         keep_limit;
    logic [IMP_W-1:0]          gate;
    logic signed [SCORE_W-1:0] kept_score [K_DEF];
    logic [INDEX_W-1:0]        kept_slot [K_DEF];
    int                        held;
    res_t                      due_results [$];

    // Number of positions the list really has under the current setting.
    function automatic int list_size();
        int k;
        k = keep_limit;
        if (k > K_DEF)
            k = K_DEF;
        if (k > MAX_ENTRIES_DEF)
            k = MAX_ENTRIES_DEF;
        return k;
    endfunction

    // Similarity times importance, shifted down 16 places with floor.
    function automatic logic signed [SCORE_W-1:0] weigh(logic signed [SCORE_W-1:0] sim,
                                                        logic [IMP_W-1:0] imp);
        longint prod;
        prod = longint'(sim) * longint'(imp);
        return SCORE_W'(prod >>> 16);
    endfunction

    // Insertion into the descending list; equal scores stay behind earlier ones.
    function automatic void keep_score(logic signed [SCORE_W-1:0] score,
                                       logic [INDEX_W-1:0] slot);
        int k;
        int pos;
        bit full;
        k = list_size();
        if (k == 0)
            return;
        full = held >= k;
        if (full && !(score > kept_score[k-1]))
            return;
        pos = full ? k - 1 : held;
        if (!full)
            held++;
        while (pos > 0 && kept_score[pos-1] < score)
        begin
            kept_score[pos] = kept_score[pos-1];
            kept_slot[pos]  = kept_slot[pos-1];
            pos--;
        end
        kept_score[pos] = score;
        kept_slot[pos]  = slot;
    endfunction

    // A candidate is filtered, saturated and then scored.
    function automatic void take_candidate(cand_t c);
        logic [IMP_W-1:0] imp;
        imp = (c.importance > IMP_ONE) ? IMP_ONE : c.importance;
        if (!c.entry_active || !c.user_match)
            return;
        if (c.entry_index >= MAX_ENTRIES_DEF)
            return;
        if (imp < gate)
            return;
        keep_score(weigh(c.similarity, imp), c.entry_index);
    endfunction

    // A finish queues the ranked list, or a single empty answer, and clears it.
    function automatic void queue_ranking();
        int n;
        res_t r;
        n = held;
        if (n > list_size())
            n = list_size();
        held = 0;
        if (n == 0)
        begin
            r = '0;
            r.none_found = 1'b1;
            r.last = 1'b1;
            due_results.push_back(r);
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                r.rank       = RANK_W'(i);
                r.best_score = kept_score[i];
                r.best_index = kept_slot[i];
                r.none_found = 1'b0;
                r.last       = (i == n - 1);
                due_results.push_back(r);
            end
        end
    endfunction

    function automatic void report(string field, int want_v, int got_v);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
    endfunction

    // Field by field comparison against the oldest prediction.
    function automatic void check_result(res_t got);
        res_t want;
        if (due_results.size() == 0)
        begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none, got rank %0d score %0d index %0d",
                     $time, got.rank, got.best_score, got.best_index);
            return;
        end
        want = due_results.pop_front();
        if (got.rank !== want.rank)
            report("rank", want.rank, got.rank);
        if (got.best_score !== want.best_score)
            report("best_score", want.best_score, got.best_score);
        if (got.best_index !== want.best_index)
            report("best_index", want.best_index, got.best_index);
        if (got.none_found !== want.none_found)
            report("none_found", want.none_found, got.none_found);
        if (got.last !== want.last)
            report("last", want.last, got.last);
    endfunction

    // Everything is sampled at the rising edge, where transfers take place.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_limit = TOP_K_RESET;
            gate = IMP_GATE_RESET;
            held = 0;
            due_results.delete();
            results_due = 0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_addr)
                    REG_TOP_K:    keep_limit = cfg_wdata[TOPK_W-1:0];
                    REG_IMP_GATE: gate = cfg_wdata[IMP_W-1:0];
                    default:      ;
                endcase
            end
            if (cand_valid && !cand_stall)
            begin
                if (cand.command == CMD_FINISH)
                    queue_ranking();
                else
                    take_candidate(cand);
            end
            if (res_valid && !res_stall)
                check_result(res);
            results_due = due_results.size();
        end
    end

endmodule

FILE: bench/testbench.sv
// Top of the bench for the weighted similarity top-k selector: clock, reset, stimulus.
// Depends on wstk_pkg, weighted_similarity_top_k_unit and the topk_checker module.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import wstk_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int CLEAR_CYCLES = 8;
    localparam int DRAIN_CYCLES = 12;
    localparam int SCORED_ITEMS = 64;

    logic                  clk;
    logic                  rst_n;
    logic                  cand_valid;
    logic                  cand_stall;
    cand_t                 cand;
    logic                  res_valid;
    logic                  res_stall;
    res_t                  res;
    logic                  cfg_wr;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    mismatch_count;
    int                    results_due;
    int                    cycle_count = 0;
    int                    cur_gate;
    bit                    steady;

    weighted_similarity_top_k_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cand_valid (cand_valid),
        .cand_stall (cand_stall),
        .cand       (cand),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .cfg_wr     (cfg_wr),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata)
    );

    topk_checker ranking_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cand_valid     (cand_valid),
        .cand_stall     (cand_stall),
        .cand           (cand),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .res            (res),
        .cfg_wr         (cfg_wr),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The result side stalls in runs: mostly short, sometimes long, sometimes not at all.
    initial
    begin : stall_gen
        int hold;
        int pick;
        hold = 0;
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    res_stall <= 1'b0;
                    hold = $urandom_range(0, 6);
                end
                else if (pick < 65)
                begin
                    res_stall <= 1'b0;
                    hold = $urandom_range(20, 60);
                end
                else if (pick < 92)
                begin
                    res_stall <= 1'b1;
                    hold = $urandom_range(0, 2);
                end
                else
                begin
                    res_stall <= 1'b1;
                    hold = $urandom_range(8, 30);
                end
            end
        end
    end

    // Idle cycles before a candidate transfer.
    function automatic int pick_gap();
        int pick;
        if (steady)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic cand_t candidate(int sim, int imp, int idx, bit active, bit match);
        cand_t c;
        c.command      = CMD_CANDIDATE;
        c.similarity   = SCORE_W'(sim);
        c.importance   = IMP_W'(imp);
        c.entry_index  = INDEX_W'(idx);
        c.entry_active = active;
        c.user_match   = match;
        return c;
    endfunction

    // Finish carries random junk in the fields it ignores.
    function automatic cand_t finish_command();
        cand_t c;
        c = $bits(cand_t)'({$urandom, $urandom});
        c.command = CMD_FINISH;
        return c;
    endfunction

    // A candidate that gets through the filter, or one that is dropped by it.
    function automatic cand_t fresh_candidate(bit qualify);
        cand_t c;
        int pick;
        c = candidate($urandom, 0, $urandom, 1'b1, 1'b1);
        // Repeated values make equal scores likely.
        if ($urandom_range(0, 9) < 2)
        begin
            case ($urandom_range(0, 3))
                0:       c.similarity = -16'sd32768;
                1:       c.similarity = 16'sd32767;
                2:       c.similarity = '0;
                default: c.similarity = 16'sd1234;
            endcase
        end
        if (qualify)
        begin
            pick = $urandom_range(0, 9);
            if (cur_gate > IMP_ONE)
                c.importance = IMP_W'($urandom_range(0, 131071));
            else if (pick == 0)
                c.importance = IMP_W'($urandom_range(65537, 131071));
            else if (pick == 1)
                c.importance = IMP_W'(cur_gate);
            else
                c.importance = IMP_W'($urandom_range(cur_gate, 65536));
        end
        else
        begin
            c.importance = IMP_W'($urandom_range(0, 131071));
            case ($urandom_range(0, 2))
                0:
                begin
                    c.entry_active = 1'b0;
                    c.user_match = $urandom_range(0, 1);
                end
                1:
                    c.user_match = 1'b0;
                default:
                begin
                    if (cur_gate > 0)
                        c.importance = IMP_W'($urandom_range(0, cur_gate - 1));
                    else
                        c.entry_active = 1'b0;
                end
            endcase
        end
        return c;
    endfunction

    // One candidate transfer; valid stays up on return so back-to-back items flow.
    task automatic send_cand(input cand_t item);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cand_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cand_valid <= 1'b1;
        cand <= item;
        do
            @(posedge clk);
        while (cand_stall);
        @(negedge clk);
    endtask

    // Register writes happen only once the block has gone quiet.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int value);
        cand_valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (CLEAR_CYCLES) @(negedge clk);
        cfg_wr <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= CFG_DATA_W'(value);
        @(negedge clk);
        cfg_wr <= 1'b0;
        if (addr == REG_IMP_GATE)
            cur_gate = value;
    endtask

    task automatic reconfigure();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            write_reg(REG_TOP_K, 8);
        else if (pick < 45)
            write_reg(REG_TOP_K, 1);
        else if (pick < 55)
            write_reg(REG_TOP_K, $urandom_range(9, 15));
        else if (pick < 60)
            write_reg(REG_TOP_K, 0);
        else
            write_reg(REG_TOP_K, $urandom_range(1, 8));
        pick = $urandom_range(0, 99);
        if (pick < 40)
            write_reg(REG_IMP_GATE, IMP_GATE_RESET);
        else if (pick < 60)
            write_reg(REG_IMP_GATE, 0);
        else if (pick < 70)
            write_reg(REG_IMP_GATE, IMP_ONE);
        else if (pick < 80)
            write_reg(REG_IMP_GATE, $urandom_range(0, 131071));
        else
            write_reg(REG_IMP_GATE, $urandom_range(0, 40000));
    endtask

    initial
    begin
        int scored;
        int scan_len;
        rst_n = 1'b0;
        cand_valid = 1'b0;
        cand = '0;
        cfg_wr = 1'b0;
        cfg_addr = REG_TOP_K;
        cfg_wdata = '0;
        cur_gate = IMP_GATE_RESET;
        steady = 1'b0;
        scored = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Finish on an empty list gives the single empty answer.
        send_cand(finish_command());

        // Two places, no gate: extremes, saturation, a tie on a full list, filtering.
        write_reg(REG_TOP_K, 2);
        write_reg(REG_IMP_GATE, 0);
        send_cand(candidate(32767, 65536, 1023, 1'b1, 1'b1));
        send_cand(candidate(-32768, 131071, 0, 1'b1, 1'b1));
        send_cand(candidate(-32768, 65536, 5, 1'b1, 1'b1));
        send_cand(candidate(32767, 65536, 9, 1'b0, 1'b1));
        send_cand(candidate(32767, 65536, 10, 1'b1, 1'b0));
        send_cand(candidate(0, 0, 7, 1'b1, 1'b1));
        send_cand(finish_command());

        // Oversized keep count with the gate at one.
        write_reg(REG_TOP_K, 15);
        write_reg(REG_IMP_GATE, IMP_ONE);
        send_cand(candidate(32767, 65535, 3, 1'b1, 1'b1));
        send_cand(candidate(-1, 65536, 4, 1'b1, 1'b1));
        send_cand(candidate(12345, 100000, 6, 1'b1, 1'b1));
        send_cand(finish_command());

        // A keep count of zero holds nothing.
        write_reg(REG_TOP_K, 0);
        write_reg(REG_IMP_GATE, 131071);
        send_cand(candidate(500, 65536, 2, 1'b1, 1'b1));
        send_cand(finish_command());

        // Equal scores, floor rounding, then the keep count lowered during the scan.
        write_reg(REG_TOP_K, 8);
        write_reg(REG_IMP_GATE, IMP_GATE_RESET);
        for (int i = 11; i < 15; i++)
            send_cand(candidate(1000, 32768, i, 1'b1, 1'b1));
        send_cand(candidate(1, 32768, 15, 1'b1, 1'b1));
        send_cand(candidate(-1, 3277, 16, 1'b1, 1'b1));
        send_cand(candidate(100, 3276, 17, 1'b1, 1'b1));
        write_reg(REG_TOP_K, 3);
        send_cand(candidate(2000, 65536, 18, 1'b1, 1'b1));
        send_cand(finish_command());

        // Random scans: mostly scoring candidates, some dropped ones, then a finish.
        while (scored < SCORED_ITEMS)
        begin
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) == 0)
                reconfigure();
            scan_len = $urandom_range(0, 12);
            for (int i = 0; i < scan_len; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_cand(fresh_candidate(1'b0));
                else
                begin
                    send_cand(fresh_candidate(1'b1));
                    scored++;
                end
                if (i == scan_len / 2 && $urandom_range(0, 7) == 0)
                    write_reg(REG_TOP_K, $urandom_range(0, 15));
            end
            send_cand(finish_command());
            scored++;
        end

        // Let the last results drain, then give the verdict.
        cand_valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/wstk_pkg.sv
rtl/core/wstk_cell.sv
rtl/core/weighted_similarity_top_k_unit.sv
rtl/core/wstk_checker.sv
bench/topk_checker.sv
bench/testbench.sv
